### design/amru_pkg.sv
// Shared types and constants for the adaptive momentum / rms weight update block.
// No dependencies; used by every module of the block except amru_ram.
package amru_pkg;

    localparam int IDX_W     = 12;
    localparam int DATA_W    = 32;
    localparam int LR_W      = 24;
    localparam int MF_W      = 16;
    localparam int GAIN_W    = 16;
    localparam int SIGN_W    = 2;
    localparam int P_W       = 36;
    localparam int R_W       = 30;
    localparam int X_W       = 33;
    localparam int PP_W      = 65;
    localparam int QQ_W      = 64;
    localparam int TRIAL_W   = 96;
    localparam int ISQRT_STEPS = 30;

    localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'd0;
    localparam logic [SIGN_W-1:0] SIGN_POS  = 2'd1;
    localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'd2;

    localparam logic [DATA_W-1:0] S_ONE       = 32'd65536;
    localparam logic [X_W-1:0]    S_EPS       = 33'd66;
    localparam logic [GAIN_W-1:0] GAIN_ONE    = 16'd4096;
    localparam logic [16:0]       GAIN_STEP   = 17'd205;
    localparam logic [11:0]       GAIN_SHRINK = 12'd3891;
    localparam logic [16:0]       GAIN_MAX    = 17'd40960;
    localparam logic [16:0]       GAIN_MIN    = 17'd2048;
    localparam logic [15:0]       S_DECAY     = 16'd58982;
    localparam logic [12:0]       S_NEW       = 13'd6554;
    localparam logic [MF_W-1:0]   MF_RESET    = 16'd58982;

    localparam logic REG_MOMENTUM = 1'b0;
    localparam logic REG_GAIN_EN  = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] m;
        logic [DATA_W-1:0] s;
        logic [GAIN_W-1:0] gain;
        logic [SIGN_W-1:0] sign;
    } t_ram;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic              inrange;
        logic [DATA_W-1:0] m;
        logic [DATA_W-1:0] s;
        logic [GAIN_W-1:0] gain;
    } t_upd;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             inrange;
        logic             neg;
        logic [P_W-1:0]   p;
    } t_tag;

endpackage

### design/amru_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module amru_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                        i_wdata,
    input  logic                                i_re,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                        o_rdata
);

    logic [W-1:0] r_mem [0:D-1];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/amru_state.sv
// Per-weight state read-modify-write: momentum, mean square, gain and last sign.
// Depends on amru_pkg and amru_ram.
module amru_state #(
    parameter int NUM_WEIGHTS = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [amru_pkg::IDX_W-1:0]    i_idx,
    input  logic signed [amru_pkg::DATA_W-1:0] i_grad,
    input  logic [amru_pkg::LR_W-1:0]     i_lr,
    input  logic                          i_first,
    input  logic [amru_pkg::MF_W-1:0]     i_momentum_factor,
    input  logic                          i_gain_en,
    output logic                          o_valid,
    input  logic                          i_ready,
    output amru_pkg::t_upd                o_upd
);

    localparam int AW = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;

    // stage a: input word
    logic                            r_a_valid;
    logic [amru_pkg::IDX_W-1:0]      r_a_idx;
    logic signed [amru_pkg::DATA_W-1:0] r_a_grad;
    logic [amru_pkg::LR_W-1:0]       r_a_lr;
    logic                            r_a_first;

    // stage b: memory data available
    logic                            r_b_valid;
    logic [amru_pkg::IDX_W-1:0]      r_b_idx;
    logic                            r_b_inrange;
    logic                            r_b_first;
    logic signed [56:0]              r_b_lrg;
    logic [30:0]                     r_b_gsq;
    logic [amru_pkg::SIGN_W-1:0]     r_b_sign;
    logic                            r_b_fwd;
    amru_pkg::t_ram                  r_b_fwd_data;

    // stage c: updated state
    logic                            r_c_valid;
    amru_pkg::t_upd                  r_c;

    logic c_ready, b_ready, a_ready, mv_a, mv_b;
    logic [AW-1:0] w_raddr, w_waddr;
    logic w_we;
    amru_pkg::t_ram w_rdata, n_st;

    logic [31:0] c_gmag;
    logic [63:0] c_gsq64;
    logic [amru_pkg::SIGN_W-1:0] c_sign;

    amru_pkg::t_ram c_old;
    logic signed [31:0] c_m0;
    logic signed [48:0] c_mf;
    logic signed [58:0] c_t;
    logic signed [34:0] c_tsh;
    logic [31:0] c_s0;
    logic [49:0] c_sacc;
    logic [33:0] c_ssh;
    logic [15:0] c_g0;
    logic [27:0] c_shrink;
    logic [16:0] c_g1;
    logic [16:0] c_g2;
    logic c_disagree;

    assign c_ready = !r_c_valid || i_ready;
    assign b_ready = !r_b_valid || c_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign mv_a    = r_a_valid && b_ready;
    assign mv_b    = r_b_valid && c_ready;
    assign o_ready = a_ready;

    assign w_raddr = AW'(r_a_idx);
    assign w_waddr = AW'(r_b_idx);
    assign w_we    = mv_b && r_b_inrange;

    amru_ram #(
        .W ($bits(amru_pkg::t_ram)),
        .D (NUM_WEIGHTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (n_st),
        .i_re    (mv_a),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        c_gmag  = r_a_grad[31] ? 32'(-r_a_grad) : 32'(r_a_grad);
        c_gsq64 = c_gmag * c_gmag;
        if (r_a_grad == '0) begin
            c_sign = amru_pkg::SIGN_ZERO;
        end else if (r_a_grad[31]) begin
            c_sign = amru_pkg::SIGN_NEG;
        end else begin
            c_sign = amru_pkg::SIGN_POS;
        end
    end

    always_comb begin
        c_old = r_b_fwd ? r_b_fwd_data : w_rdata;
        c_m0  = r_b_first ? 32'sd0 : $signed(c_old.m);
        c_s0  = r_b_first ? amru_pkg::S_ONE : c_old.s;
        c_g0  = r_b_first ? amru_pkg::GAIN_ONE : c_old.gain;

        // momentum
        c_mf  = c_m0 * $signed({1'b0, i_momentum_factor});
        c_t   = 59'($signed({c_mf, 8'd0})) - 59'(r_b_lrg) + 59'sd8388608;
        c_tsh = c_t[58:24];
        if (!c_tsh[34] && (|c_tsh[33:31])) begin
            n_st.m = 32'h7FFF_FFFF;
        end else if (c_tsh[34] && !(&c_tsh[33:31])) begin
            n_st.m = 32'h8000_0000;
        end else begin
            n_st.m = c_tsh[31:0];
        end

        // mean square
        c_sacc = 50'(c_s0) * 50'(amru_pkg::S_DECAY) + 50'(r_b_gsq) * 50'(amru_pkg::S_NEW)
                 + 50'd32768;
        c_ssh  = c_sacc[49:16];
        n_st.s = (|c_ssh[33:32]) ? 32'hFFFF_FFFF : c_ssh[31:0];

        // gain
        c_disagree = (c_old.sign == amru_pkg::SIGN_POS && r_b_sign == amru_pkg::SIGN_NEG)
                  || (c_old.sign == amru_pkg::SIGN_NEG && r_b_sign == amru_pkg::SIGN_POS);
        c_shrink = 28'(c_g0) * 28'(amru_pkg::GAIN_SHRINK);
        c_g1 = c_disagree ? 17'(c_shrink[27:12]) : 17'(c_g0) + amru_pkg::GAIN_STEP;
        if (c_g1 > amru_pkg::GAIN_MAX) begin
            c_g2 = amru_pkg::GAIN_MAX;
        end else if (c_g1 < amru_pkg::GAIN_MIN) begin
            c_g2 = amru_pkg::GAIN_MIN;
        end else begin
            c_g2 = c_g1;
        end
        n_st.gain = (!r_b_first && i_gain_en) ? c_g2[15:0] : c_g0;
        n_st.sign = r_b_sign;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (c_ready) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a_idx   <= i_idx;
            r_a_grad  <= i_grad;
            r_a_lr    <= i_lr;
            r_a_first <= i_first;
        end
        if (mv_a) begin
            r_b_idx      <= r_a_idx;
            r_b_inrange  <= 32'(r_a_idx) < 32'(NUM_WEIGHTS);
            r_b_first    <= r_a_first;
            r_b_lrg      <= $signed({1'b0, r_a_lr}) * r_a_grad;
            r_b_gsq      <= c_gsq64[62:32];
            r_b_sign     <= c_sign;
            // write in the same cycle as the read returns old data
            r_b_fwd      <= w_we && (w_waddr == w_raddr);
            r_b_fwd_data <= n_st;
        end
        if (mv_b) begin
            r_c.idx     <= r_b_idx;
            r_c.inrange <= r_b_inrange;
            r_c.m       <= n_st.m;
            r_c.s       <= n_st.s;
            r_c.gain    <= n_st.gain;
        end
    end

    assign o_valid = r_c_valid;
    assign o_upd   = r_c;

endmodule

### design/amru_rsqrt.sv
// Pipelined inverse square root: r = floor(2^32 / sqrt(s + eps)), one bit per stage.
// Also forms the rounded momentum-times-gain product. Depends on amru_pkg.
module amru_rsqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  amru_pkg::t_upd             i_upd,
    output logic                       o_valid,
    input  logic                       i_ready,
    output amru_pkg::t_tag             o_tag,
    output logic [amru_pkg::R_W-1:0]   o_r
);

    localparam int NS = amru_pkg::ISQRT_STEPS;
    localparam int TW = amru_pkg::TRIAL_W;

    logic                           r_v   [0:NS];
    amru_pkg::t_tag                 r_tag [0:NS];
    logic [amru_pkg::X_W-1:0]       r_x   [0:NS];
    logic [amru_pkg::R_W-1:0]       r_r   [0:NS];
    logic [amru_pkg::PP_W-1:0]      r_pp  [0:NS];
    logic [amru_pkg::QQ_W-1:0]      r_qq  [0:NS];
    logic                           w_rdy [0:NS+1];

    logic [31:0] c_mmag;
    logic [47:0] c_prod;

    assign w_rdy[NS+1] = i_ready;
    assign o_ready     = w_rdy[0];

    always_comb begin
        c_mmag = i_upd.m[31] ? 32'(-$signed(i_upd.m)) : i_upd.m;
        c_prod = 48'(c_mmag) * 48'(i_upd.gain) + 48'd2048;
    end

    assign w_rdy[0] = !r_v[0] || w_rdy[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_rdy[0]) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_tag[0].idx     <= i_upd.idx;
            r_tag[0].inrange <= i_upd.inrange;
            r_tag[0].neg     <= i_upd.m[31];
            r_tag[0].p       <= c_prod[47:12];
            r_x[0]           <= amru_pkg::X_W'(i_upd.s) + amru_pkg::S_EPS;
            r_r[0]           <= '0;
            r_pp[0]          <= '0;
            r_qq[0]          <= '0;
        end
    end

    for (genvar j = 1; j <= NS; j++) begin : g_step
        localparam int K = NS - j;
        logic [TW-1:0] c_trial;
        logic          c_ok;

        assign w_rdy[j] = !r_v[j] || w_rdy[j+1];
        assign c_trial  = TW'(r_pp[j-1]) + (TW'(r_qq[j-1]) << (K + 1))
                        + (TW'(r_x[j-1]) << (2 * K));
        assign c_ok     = c_trial <= (TW'(1) << 64);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (w_rdy[j]) begin
                r_v[j] <= r_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[j] && r_v[j-1]) begin
                r_tag[j] <= r_tag[j-1];
                r_x[j]   <= r_x[j-1];
                if (c_ok) begin
                    r_r[j]  <= r_r[j-1] | (amru_pkg::R_W'(1) << K);
                    r_pp[j] <= c_trial[amru_pkg::PP_W-1:0];
                    r_qq[j] <= r_qq[j-1] + (amru_pkg::QQ_W'(r_x[j-1]) << K);
                end else begin
                    r_r[j]  <= r_r[j-1];
                    r_pp[j] <= r_pp[j-1];
                    r_qq[j] <= r_qq[j-1];
                end
            end
        end
    end

    assign o_valid = r_v[NS];
    assign o_tag   = r_tag[NS];
    assign o_r     = r_r[NS];

endmodule

### design/adaptive_momentum_rms_weight_update.sv
// Top level of the per-weight optimizer step: config port, state update,
// inverse square root and the saturated delta. Depends on amru_pkg and submodules.
// Throughput: one word per cycle while m_axis_tready does not stall the pipeline,
// for any index sequence; state forwarding covers repeats.
// Reset clears pipeline valid bits and the config registers; state memory is not cleared.
module adaptive_momentum_rms_weight_update #(
    parameter int NUM_WEIGHTS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // weight_index, gradient, learn_rate, zero pad
    input  logic [0:0]  s_axis_tuser,  // first_iteration
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // delta_index, weight_delta, zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [amru_pkg::MF_W-1:0] r_momentum_factor;
    logic                      r_gain_en;
    logic                      w_cfg_wr;

    logic           w_st_valid, w_st_ready;
    amru_pkg::t_upd w_upd;
    logic           w_rs_valid, w_rs_ready;
    amru_pkg::t_tag w_tag;
    logic [amru_pkg::R_W-1:0] w_r;

    logic           r_e_valid;
    amru_pkg::t_tag r_e_tag;
    logic [49:0]    r_e_a;
    logic [52:0]    r_e_b;
    logic           r_f_valid;
    logic [amru_pkg::IDX_W-1:0]  r_f_idx;
    logic [amru_pkg::DATA_W-1:0] r_f_delta;

    logic e_ready, f_ready;
    logic [66:0] c_sum;
    logic [42:0] c_mag;
    logic [31:0] c_delta;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == amru_pkg::REG_GAIN_EN) ? {31'd0, r_gain_en}
                                                          : {16'd0, r_momentum_factor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_momentum_factor <= amru_pkg::MF_RESET;
            r_gain_en         <= 1'b1;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                amru_pkg::REG_MOMENTUM: r_momentum_factor <= pwdata[15:0];
                amru_pkg::REG_GAIN_EN:  r_gain_en         <= pwdata[0];
                default: ;
            endcase
        end
    end

    amru_state #(
        .NUM_WEIGHTS (NUM_WEIGHTS)
    ) u_state (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (s_axis_tvalid),
        .o_ready           (s_axis_tready),
        .i_idx             (s_axis_tdata[11:0]),
        .i_grad            ($signed(s_axis_tdata[43:12])),
        .i_lr              (s_axis_tdata[67:44]),
        .i_first           (s_axis_tuser[0]),
        .i_momentum_factor (r_momentum_factor),
        .i_gain_en         (r_gain_en),
        .o_valid           (w_st_valid),
        .i_ready           (w_st_ready),
        .o_upd             (w_upd)
    );

    amru_rsqrt u_rsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_st_valid),
        .o_ready (w_st_ready),
        .i_upd   (w_upd),
        .o_valid (w_rs_valid),
        .i_ready (w_rs_ready),
        .o_tag   (w_tag),
        .o_r     (w_r)
    );

    assign f_ready    = !r_f_valid || m_axis_tready;
    assign e_ready    = !r_e_valid || f_ready;
    assign w_rs_ready = e_ready;

    always_comb begin
        c_sum = {1'b0, r_e_a, 16'd0} + 67'(r_e_b);
        c_mag = c_sum[66:24];
        if (!r_e_tag.inrange) begin
            c_delta = '0;
        end else if (r_e_tag.neg) begin
            c_delta = (c_mag >= 43'h8000_0000) ? 32'h8000_0000 : 32'(-c_mag);
        end else begin
            c_delta = (c_mag > 43'h7FFF_FFFF) ? 32'h7FFF_FFFF : c_mag[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
        end else begin
            if (e_ready) begin
                r_e_valid <= w_rs_valid;
            end
            if (f_ready) begin
                r_f_valid <= r_e_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_ready && w_rs_valid) begin
            r_e_tag <= w_tag;
            r_e_a   <= 50'(w_tag.p) * 50'(w_r[29:16]);
            r_e_b   <= 53'(w_tag.p) * 53'(w_r[15:0]) + 53'd8388608;
        end
        if (f_ready && r_e_valid) begin
            r_f_idx   <= r_e_tag.idx;
            r_f_delta <= c_delta;
        end
    end

    assign m_axis_tvalid = r_f_valid;
    assign m_axis_tdata  = {4'd0, r_f_delta, r_f_idx};

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Testbench for adaptive_momentum_rms_weight_update: random and directed gradient words,
// a per-weight optimizer predictor in a scoreboard class, random gaps and stalls.
// Depends on amru_pkg and the block's RTL.
module tb;

    localparam int NW = 4096;
    localparam int LIMIT = 1000000;

    typedef struct {
        logic [amru_pkg::IDX_W-1:0]  idx;
        logic [amru_pkg::DATA_W-1:0] delta;
    } t_delta;

    class t_delta_board;
        logic [amru_pkg::DATA_W-1:0] mom[NW];
        logic [amru_pkg::DATA_W-1:0] msq[NW];
        logic [amru_pkg::GAIN_W-1:0] gn[NW];
        logic [amru_pkg::SIGN_W-1:0] sg[NW];
        logic [amru_pkg::MF_W-1:0]   mf;
        logic                        adapt;
        t_delta                      pending[$];
        int                          errors;

        function new();
            mf = amru_pkg::MF_RESET;
            adapt = 1'b1;
            errors = 0;
        endfunction

        function automatic longint unsigned sqrt_floor(longint unsigned v);
            longint unsigned rem, res, b;
            rem = v;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (rem >= res + b) begin
                    rem -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function void note(logic [amru_pkg::IDX_W-1:0] idx, logic [amru_pkg::DATA_W-1:0] grad,
                           logic [amru_pkg::LR_W-1:0] lr, logic first);
            longint g, m0, t, m;
            longint unsigned s0, gmag, gsq, s, x, q, r, mmag, p, mag;
            logic [64:0] num;
            logic [127:0] prod;
            int unsigned gain;
            logic [amru_pkg::SIGN_W-1:0] cur;
            t_delta e;
            g = longint'($signed(grad));
            m0 = first ? 0 : longint'($signed(mom[idx]));
            s0 = first ? 64'd65536 : longint'(msq[idx]);
            gain = first ? 4096 : gn[idx];
            cur = g > 0 ? amru_pkg::SIGN_POS : (g < 0 ? amru_pkg::SIGN_NEG : amru_pkg::SIGN_ZERO);
            t = m0 * longint'(mf) * 256 - longint'(lr) * g;
            m = (t + (64'sd1 << 23)) >>> 24;
            if (m > 64'sd2147483647) m = 64'sd2147483647;
            if (m < -64'sd2147483648) m = -64'sd2147483648;
            if (!first && adapt) begin
                if ((sg[idx] == amru_pkg::SIGN_POS && cur == amru_pkg::SIGN_NEG) ||
                    (sg[idx] == amru_pkg::SIGN_NEG && cur == amru_pkg::SIGN_POS))
                    gain = (gain * 3891) >> 12;
                else
                    gain = gain + 205;
                if (gain > 40960) gain = 40960;
                if (gain < 2048) gain = 2048;
            end
            gmag = g < 0 ? -g : g;
            gsq = (gmag * gmag) >> 32;
            s = (s0 * 58982 + gsq * 6554 + 32768) >> 16;
            if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
            x = s + 66;
            num = 65'd1 << 64;
            q = num / x;
            r = sqrt_floor(q);
            mmag = m < 0 ? -m : m;
            p = (mmag * gain + 2048) >> 12;
            prod = {64'd0, p} * {64'd0, r};
            prod = (prod + (128'd1 << 23)) >> 24;
            mag = prod[63:0];
            if (prod[127:64] != 0) mag = 64'hFFFF_FFFF_FFFF_FFFF;
            e.idx = idx;
            if (m < 0)
                e.delta = mag >= 64'h8000_0000 ? 32'h8000_0000 : 32'(-longint'(mag));
            else
                e.delta = mag > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : mag[31:0];
            mom[idx] = m[31:0];
            msq[idx] = s[31:0];
            gn[idx] = gain[15:0];
            sg[idx] = cur;
            pending.insert(pending.size(), e);
        endfunction

        function void check(logic [amru_pkg::IDX_W-1:0] idx, logic [amru_pkg::DATA_W-1:0] delta);
            t_delta e;
            if (pending.size() == 0) begin
                $error("unexpected delta word idx=%0d delta=%h", idx, delta);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (idx !== e.idx) begin
                $error("delta_index expected %0d actual %0d", e.idx, idx);
                errors++;
            end
            if (delta !== e.delta) begin
                $error("weight_delta expected %h actual %h", e.delta, delta);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // weight_index, gradient, learn_rate, zero pad
    logic [0:0]  s_axis_tuser;   // first_iteration
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // delta_index, weight_delta, zero pad
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;

    adaptive_momentum_rms_weight_update dut (.*);

    t_delta_board board;
    bit           quiet;
    bit           written[NW];
    int           cycles;
    int           stall_left;
    logic         hot_sign[8];

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int gap_len();
        int v;
        if (quiet) return 0;
        v = $urandom_range(0, 99);
        if (v < 55) return 0;
        if (v < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left <= gap_len();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check(m_axis_tdata[11:0], m_axis_tdata[43:12]);
    end

    task automatic reg_write(input logic idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {1'b0, idx, 1'b0} << 1;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == amru_pkg::REG_MOMENTUM) board.mf = val[15:0];
        else board.adapt = val[0];
    endtask

    task automatic send_word(input logic [11:0] idx, input logic [31:0] grad,
                             input logic [23:0] lr, input logic first);
        int n;
        n = gap_len();
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        if (!written[idx]) first = 1'b1;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'd0, lr, grad, idx};
        s_axis_tuser <= first;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note(idx, grad, lr, first);
        written[idx] = 1'b1;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_grad();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
            2: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
            3: return {{8{1'b0}}, 24'($urandom())};
            4: return 32'(-int'($urandom_range(0, 1 << 24)));
            default: return 32'($signed($urandom_range(0, 1 << 28)) - (1 << 27));
        endcase
    endfunction

    task automatic random_phase(input int count);
        int k, h;
        logic [11:0] idx;
        logic [31:0] grad;
        logic [23:0] lr;
        for (k = 0; k < count; k++) begin
            if (k % 120 == 0) quiet = ($urandom_range(0, 3) == 0);
            grad = rand_grad();
            lr = $urandom_range(0, 3) == 0 ? 24'($urandom()) : 24'($urandom_range(0, 1 << 20));
            if ($urandom_range(0, 99) < 70) begin
                h = $urandom_range(0, 7);
                idx = 12'(h * 517);
                if (h % 3 == 0 && $urandom_range(0, 9) != 0)
                    grad[31] = hot_sign[h];
                else if (h % 3 == 1) begin
                    hot_sign[h] = ~hot_sign[h];
                    grad[31] = hot_sign[h];
                end
            end else begin
                idx = 12'($urandom());
            end
            send_word(idx, grad, lr, $urandom_range(0, 19) == 0);
        end
        quiet = 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        board = new();
        cycles = 0;
        quiet = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        foreach (hot_sign[i]) hot_sign[i] = i[0];
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, sign agreement and disagreement cases, zero gradient
        send_word(12'd0, 32'h7FFF_FFFF, 24'hFFFFFF, 1'b1);
        send_word(12'd4095, 32'h8000_0000, 24'hFFFFFF, 1'b1);
        send_word(12'd1, 32'd0, 24'd0, 1'b1);
        send_word(12'd2, 32'hFFFF_FFFF, 24'hFFFFFF, 1'b1);
        send_word(12'd0, 32'h7FFF_FFFF, 24'hFFFFFF, 1'b0);
        send_word(12'd0, 32'h8000_0000, 24'hFFFFFF, 1'b0);
        send_word(12'd0, 32'd0, 24'h800000, 1'b0);
        send_word(12'd0, 32'h0100_0000, 24'h000001, 1'b0);
        send_word(12'd4095, 32'h8000_0000, 24'hFFFFFF, 1'b0);
        send_word(12'd4095, 32'h8000_0000, 24'd0, 1'b0);
        send_word(12'd1, 32'hFF00_0000, 24'h100000, 1'b0);
        send_word(12'd1, 32'h0100_0000, 24'h100000, 1'b0);
        send_word(12'd2, 32'h0000_0001, 24'd0, 1'b0);
        send_word(12'd2, 32'h7FFF_FFFF, 24'hFFFFFF, 1'b1);
        random_phase(360);
        drain();

        reg_write(amru_pkg::REG_MOMENTUM, 32'd0);
        reg_write(amru_pkg::REG_GAIN_EN, 32'd0);
        random_phase(360);
        drain();

        reg_write(amru_pkg::REG_MOMENTUM, 32'd65535);
        reg_write(amru_pkg::REG_GAIN_EN, 32'd1);
        random_phase(380);
        drain();

        reg_write(amru_pkg::REG_MOMENTUM, 32'd32768);
        reg_write(amru_pkg::REG_GAIN_EN, 32'd0);
        random_phase(360);
        drain();

        reg_write(amru_pkg::REG_MOMENTUM, $urandom());
        reg_write(amru_pkg::REG_GAIN_EN, 32'd1);
        random_phase(370);
        drain();

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
